FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with the reset active as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/o1ds_pkg.sv
// ---------------------------------------------------------------------------
// o1ds_pkg
// Types and constants shared by the optimal 1-D segmentation block.
// ---------------------------------------------------------------------------
package o1ds_pkg;

    localparam int DEF_MAX_SAMPLES = 32;
    localparam int DEF_FRAC_BITS   = 8;
    localparam int SAMPLE_W        = 16;
    localparam int SEG_START_W     = 6;
    localparam int SEG_COUNT_W     = 7;
    localparam int SHORT_LIMIT     = 3;
    localparam int DIV_RADIX       = 4;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SHORT,
        S_D_CLR,
        S_D_RD,
        S_D_SQ,
        S_D_ADD,
        S_D_MUL,
        S_D_LD,
        S_D_DIV,
        S_D_WR,
        S_P_RD,
        S_P_CMP,
        S_P_WR,
        S_C_RD,
        S_C_CMP,
        S_B_INIT,
        S_B_RD,
        S_B_STEP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic smp_wr;
        logic smp_rd;
        logic acc_clr;
        logic acc_sq;
        logic acc_add;
        logic mul;
        logic div_ld;
        logic d_wr;
        logic dp_rd;
        logic dp_cmp;
        logic dp_first;
        logic dp_wr;
        logic cnt_rd;
        logic cnt_cmp;
        logic short_set;
        logic bt_init;
        logic bt_rd;
        logic bt_step;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic count_one;
    } t_sts;

endpackage

FILE: src/o1ds_datapath.sv
// ---------------------------------------------------------------------------
// o1ds_datapath
// Sample store, segment cost unit with a radix-16 divider, loss and split
// tables, count selection and backtracking of segment starts.
// ---------------------------------------------------------------------------
module o1ds_datapath
    import o1ds_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    localparam int IW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [IW-1:0]              i_n,
    input  logic [IW-1:0]              i_i,
    input  logic [IW-1:0]              i_j,
    input  logic [IW-1:0]              i_l,
    input  logic [IW-1:0]              i_k,
    input  logic [IW-1:0]              i_c,
    output t_sts                       o_sts,
    output logic [IW-1:0]              o_count,
    output logic [SEG_START_W-1:0]     o_segment_start,
    output logic [SEG_COUNT_W-1:0]     o_segment_count
);

    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int S1W    = SAMPLE_W + AW + 1;
    localparam int SQW    = 2 * SAMPLE_W - 1;
    localparam int S2W    = SQW + AW;
    localparam int NW     = S2W + IW;
    localparam int DW     = NW + FRAC_BITS;
    localparam int DVW    = ((DW + DIV_RADIX - 1) / DIV_RADIX) * DIV_RADIX;
    localparam int DSTEPS = DVW / DIV_RADIX;
    localparam int DCW    = $clog2(DSTEPS + 1);

    logic signed [SAMPLE_W-1:0] r_smp [0:MAX_SAMPLES-1];
    logic [DW-1:0]              r_dmem [0:MAX_SAMPLES-1][0:MAX_SAMPLES-1];
    logic [DW-1:0]              r_lmem [0:MAX_SAMPLES][0:MAX_SAMPLES];
    logic [IW-1:0]              r_smem [0:MAX_SAMPLES][0:MAX_SAMPLES];
    logic [AW-1:0]              r_start [0:MAX_SAMPLES-1];

    logic signed [SAMPLE_W-1:0] r_smp_q;
    logic signed [SAMPLE_W-1:0] r_v;
    logic [SQW-1:0]             r_sq;
    logic signed [S1W-1:0]      r_s1;
    logic [S2W-1:0]             r_s2;
    logic [NW-1:0]              r_p1;
    logic [NW-1:0]              r_p2;
    logic [DVW-1:0]             r_dvd;
    logic [IW:0]                r_rem;
    logic [IW-1:0]              r_m;
    logic [DCW-1:0]             r_div_cnt;
    logic [DW-1:0]              r_lq;
    logic [DW-1:0]              r_dq;
    logic                       r_diag;
    logic [DW-1:0]              r_best;
    logic [IW-1:0]              r_at;
    logic [DW-1:0]              r_prev;
    logic [DW-1:0]              r_drop;
    logic [IW-1:0]              r_count;
    logic [IW-1:0]              r_row;
    logic [IW-1:0]              r_split;
    logic                       r_bdiag;

    logic [DVW-1:0]             n_dvd;
    logic [IW:0]                n_rem;
    logic signed [2*SAMPLE_W-1:0] w_prod;
    logic [IW-1:0]              w_m;
    logic [S1W-1:0]             w_a1;
    logic [2*S1W-1:0]           w_a1sq;
    logic [NW-1:0]              w_num;
    logic [DW-1:0]              w_q;
    logic [IW-1:0]              w_im1;
    logic [IW-1:0]              w_km1;
    logic [IW-1:0]              w_lm1;
    logic [IW-1:0]              w_jp1;
    logic [IW-1:0]              w_lw_row;
    logic [IW-1:0]              w_lw_col;
    logic [DW-1:0]              w_lw_data;
    logic                       w_lw_en;
    logic [IW-1:0]              w_lr_row;
    logic [IW-1:0]              w_lr_col;
    logic [DW-1:0]              w_cand;
    logic [DW-1:0]              w_d;
    logic [IW-1:0]              w_idx;
    logic [IW-1:0]              w_cm1;

    assign w_prod = r_smp_q * r_smp_q;
    assign w_m    = i_j - i_i + IW'(1);
    assign w_a1   = r_s1[S1W-1] ? S1W'(-r_s1) : S1W'(r_s1);
    assign w_a1sq = w_a1 * w_a1;
    assign w_num  = r_p1 - r_p2;
    assign w_q    = r_dvd[DW-1:0];
    assign w_im1  = i_i - IW'(1);
    assign w_km1  = i_k - IW'(1);
    assign w_lm1  = i_l - IW'(1);
    assign w_jp1  = i_j + IW'(1);
    assign w_cm1  = i_c - IW'(1);
    assign w_cand = (r_diag ? '0 : r_lq) + r_dq;
    assign w_d    = (r_prev > r_lq) ? (r_prev - r_lq) : (r_lq - r_prev);
    assign w_idx  = (r_bdiag ? r_row : r_split) - IW'(1);

    // Loss table ports: the first column is filled during the cost pass.
    always_comb begin
        if (i_cmd.d_wr) begin
            w_lw_row  = w_jp1;
            w_lw_col  = IW'(1);
            w_lw_data = w_q;
            w_lw_en   = (i_i == '0);
        end else begin
            w_lw_row  = i_l;
            w_lw_col  = i_k;
            w_lw_data = r_best;
            w_lw_en   = i_cmd.dp_wr;
        end
        if (i_cmd.dp_rd) begin
            w_lr_row = w_im1;
            w_lr_col = w_km1;
        end else begin
            w_lr_row = i_n;
            w_lr_col = i_c;
        end
    end

    // Restoring division, DIV_RADIX quotient bits per cycle.
    always_comb begin
        logic [IW:0]    rem;
        logic [DVW-1:0] dvd;
        rem = r_rem;
        dvd = r_dvd;
        for (int b = 0; b < DIV_RADIX; b++) begin
            rem = {rem[IW-1:0], dvd[DVW-1]};
            dvd = {dvd[DVW-2:0], 1'b0};
            if (rem >= {1'b0, r_m}) begin
                rem    = rem - {1'b0, r_m};
                dvd[0] = 1'b1;
            end
        end
        n_rem = rem;
        n_dvd = dvd;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_wr) begin
            r_smp[i_n[AW-1:0]] <= i_sample;
        end
        if (i_cmd.smp_rd) begin
            r_smp_q <= r_smp[i_j[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.d_wr) begin
            r_dmem[i_i[AW-1:0]][i_j[AW-1:0]] <= w_q;
        end
        if (i_cmd.dp_rd) begin
            r_dq <= r_dmem[w_im1[AW-1:0]][w_lm1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lw_en) begin
            r_lmem[w_lw_row][w_lw_col] <= w_lw_data;
        end
        if (i_cmd.dp_rd || i_cmd.cnt_rd) begin
            r_lq <= r_lmem[w_lr_row][w_lr_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dp_wr) begin
            r_smem[i_l][i_k] <= r_at;
        end
        if (i_cmd.bt_rd) begin
            r_split <= r_smem[r_row][i_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_ld) begin
            r_div_cnt <= DCW'(DSTEPS);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end
        if (i_cmd.acc_sq) begin
            r_sq <= w_prod[SQW-1:0];
            r_v  <= r_smp_q;
        end
        if (i_cmd.acc_add) begin
            r_s1 <= r_s1 + S1W'(r_v);
            r_s2 <= r_s2 + S2W'(r_sq);
        end
        if (i_cmd.mul) begin
            r_p1 <= w_m * r_s2;
            r_p2 <= w_a1sq[NW-1:0];
        end
        if (i_cmd.div_ld) begin
            r_dvd <= DVW'(w_num) << FRAC_BITS;
            r_rem <= '0;
            r_m   <= w_m;
        end else if (r_div_cnt != '0) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
        if (i_cmd.dp_rd) begin
            r_diag <= (i_i == i_k);
        end
        if (i_cmd.dp_cmp && (i_cmd.dp_first || w_cand < r_best)) begin
            r_best <= w_cand;
            r_at   <= i_i;
        end
    end

    // Segment count: the largest drop in loss between successive counts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.short_set) begin
            r_count <= i_n;
        end
        if (i_cmd.cnt_cmp) begin
            r_prev <= r_lq;
            if (i_c == IW'(3)) begin
                r_drop  <= w_d;
                r_count <= IW'(3);
            end else if (i_c > IW'(3) && r_drop < w_d) begin
                r_drop  <= w_d;
                r_count <= i_c;
            end
        end
        if (i_cmd.bt_init) begin
            r_row      <= i_n;
            r_start[0] <= '0;
        end
        if (i_cmd.bt_rd) begin
            r_bdiag <= (r_row == i_c);
        end
        if (i_cmd.bt_step) begin
            r_start[w_cm1[AW-1:0]] <= w_idx[AW-1:0];
            r_row                  <= w_idx;
        end
    end

    assign o_sts.div_busy  = (r_div_cnt != '0);
    assign o_sts.count_one = (r_count == IW'(1));
    assign o_count         = r_count;
    assign o_segment_start = SEG_START_W'(r_start[i_c[AW-1:0]]);
    assign o_segment_count = SEG_COUNT_W'(r_count);

endmodule

FILE: src/o1ds_ctrl.sv
// ---------------------------------------------------------------------------
// o1ds_ctrl
// Sequencer: loading, cost pass, dynamic program, count choice,
// backtracking and result delivery.
// ---------------------------------------------------------------------------
module o1ds_ctrl
    import o1ds_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    localparam int IW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_sample,
    input  logic          i_out_stall,
    input  t_sts          i_sts,
    input  logic [IW-1:0] i_count,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output logic          o_truncated,
    output logic          o_last_result,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_n,
    output logic [IW-1:0] o_i,
    output logic [IW-1:0] o_j,
    output logic [IW-1:0] o_l,
    output logic [IW-1:0] o_k,
    output logic [IW-1:0] o_c
);

    t_state        r_state, n_state;
    logic [IW-1:0] r_n, n_n;
    logic          r_ovf, n_ovf;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_l, n_l;
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] r_c, n_c;
    logic          w_room;
    logic [IW-1:0] w_n_new;

    assign w_room  = (r_n < IW'(MAX_SAMPLES));
    assign w_n_new = w_room ? r_n + IW'(1) : r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_l     <= '0;
            r_k     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
            r_l     <= n_l;
            r_k     <= n_k;
            r_c     <= n_c;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_l         = r_l;
        n_k         = r_k;
        n_c         = r_c;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (w_room) begin
                        o_cmd.smp_wr = 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_n = w_n_new;
                    if (i_last_sample) begin
                        n_i = '0;
                        n_j = '0;
                        n_state = (w_n_new <= IW'(SHORT_LIMIT)) ? S_SHORT : S_D_CLR;
                    end
                end
            end
            S_SHORT: begin
                o_cmd.short_set = 1'b1;
                n_state = S_B_INIT;
            end
            S_D_CLR: begin
                o_cmd.acc_clr = 1'b1;
                n_state = S_D_RD;
            end
            S_D_RD: begin
                o_cmd.smp_rd = 1'b1;
                n_state = S_D_SQ;
            end
            S_D_SQ: begin
                o_cmd.acc_sq = 1'b1;
                n_state = S_D_ADD;
            end
            S_D_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state = S_D_MUL;
            end
            S_D_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_D_LD;
            end
            S_D_LD: begin
                o_cmd.div_ld = 1'b1;
                n_state = S_D_DIV;
            end
            S_D_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_D_WR;
                end
            end
            S_D_WR: begin
                o_cmd.d_wr = 1'b1;
                if (r_j + IW'(1) < r_n) begin
                    n_j = r_j + IW'(1);
                    n_state = S_D_RD;
                end else if (r_i + IW'(1) < r_n) begin
                    n_i = r_i + IW'(1);
                    n_j = r_i + IW'(1);
                    n_state = S_D_CLR;
                end else begin
                    n_l = IW'(3);
                    n_k = IW'(2);
                    n_i = IW'(2);
                    n_state = S_P_RD;
                end
            end
            S_P_RD: begin
                o_cmd.dp_rd = 1'b1;
                n_state = S_P_CMP;
            end
            S_P_CMP: begin
                o_cmd.dp_cmp   = 1'b1;
                o_cmd.dp_first = (r_i == r_k);
                if (r_i == r_l) begin
                    n_state = S_P_WR;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_P_RD;
                end
            end
            S_P_WR: begin
                o_cmd.dp_wr = 1'b1;
                if (r_k != r_l) begin
                    n_k = r_k + IW'(1);
                    n_i = r_k + IW'(1);
                    n_state = S_P_RD;
                end else if (r_l != r_n) begin
                    n_l = r_l + IW'(1);
                    n_k = IW'(2);
                    n_i = IW'(2);
                    n_state = S_P_RD;
                end else begin
                    n_c = IW'(2);
                    n_state = S_C_RD;
                end
            end
            S_C_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state = S_C_CMP;
            end
            S_C_CMP: begin
                o_cmd.cnt_cmp = 1'b1;
                // The last drop considered is the one into n-1 segments.
                if (r_c + IW'(1) == r_n) begin
                    n_state = S_B_INIT;
                end else begin
                    n_c = r_c + IW'(1);
                    n_state = S_C_RD;
                end
            end
            S_B_INIT: begin
                o_cmd.bt_init = 1'b1;
                if (i_sts.count_one) begin
                    n_c = '0;
                    n_state = S_EMIT;
                end else begin
                    n_c = i_count;
                    n_state = S_B_RD;
                end
            end
            S_B_RD: begin
                o_cmd.bt_rd = 1'b1;
                n_state = S_B_STEP;
            end
            S_B_STEP: begin
                o_cmd.bt_step = 1'b1;
                if (r_c == IW'(2)) begin
                    n_c = '0;
                    n_state = S_EMIT;
                end else begin
                    n_c = r_c - IW'(1);
                    n_state = S_B_RD;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (r_c + IW'(1) == i_count) begin
                        n_n   = '0;
                        n_ovf = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_c = r_c + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_truncated   = r_ovf;
    assign o_last_result = (r_c + IW'(1) == i_count);
    assign o_n = r_n;
    assign o_i = r_i;
    assign o_j = r_j;
    assign o_l = r_l;
    assign o_k = r_k;
    assign o_c = r_c;

endmodule

FILE: src/optimal_1d_segmentation.sv
// ---------------------------------------------------------------------------
// optimal_1d_segmentation
// Splits a loaded sequence of signed samples into contiguous segments of
// minimal total squared deviation and reports the start of each segment.
// ---------------------------------------------------------------------------
// Usage: samples enter on the input channel (i_in_valid / o_in_stall), one
// per cycle while loading. The item with i_last_sample set closes the
// sequence; samples beyond MAX_SAMPLES are dropped and reported through
// o_truncated. The block then stalls its input and computes. Each segment
// cost passes through a shared divider that retires 4 quotient bits per
// cycle, for all n(n+1)/2 costs; the dynamic program then weighs
// each candidate split in turn. Sequences of 3 or fewer samples
// skip both passes and give one segment per sample.
// Results leave on the output channel (o_out_valid / i_out_stall), one item
// per segment in order of start, the last one marked by o_last_result.
// While the receiver stalls, the current item holds. After the last item is
// taken the block loads again. Reset (synchronous, active low) returns it
// to loading with an empty sequence; tables need no clearing pass.
// ---------------------------------------------------------------------------
module optimal_1d_segmentation
    import o1ds_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [SEG_START_W-1:0]     o_segment_start,
    output logic [SEG_COUNT_W-1:0]     o_segment_count,
    output logic                       o_truncated,
    output logic                       o_last_result
);

    localparam int IW = $clog2(MAX_SAMPLES + 1);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [IW-1:0] w_count;
    logic [IW-1:0] w_n;
    logic [IW-1:0] w_i;
    logic [IW-1:0] w_j;
    logic [IW-1:0] w_l;
    logic [IW-1:0] w_k;
    logic [IW-1:0] w_c;

    o1ds_ctrl #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_sample(i_last_sample),
        .i_out_stall  (i_out_stall),
        .i_sts        (w_sts),
        .i_count      (w_count),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_truncated  (o_truncated),
        .o_last_result(o_last_result),
        .o_cmd        (w_cmd),
        .o_n          (w_n),
        .o_i          (w_i),
        .o_j          (w_j),
        .o_l          (w_l),
        .o_k          (w_k),
        .o_c          (w_c)
    );

    o1ds_datapath #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_sample       (i_sample),
        .i_n            (w_n),
        .i_i            (w_i),
        .i_j            (w_j),
        .i_l            (w_l),
        .i_k            (w_k),
        .i_c            (w_c),
        .o_sts          (w_sts),
        .o_count        (w_count),
        .o_segment_start(o_segment_start),
        .o_segment_count(o_segment_count)
    );

endmodule

FILE: src/o1ds_checker.sv
// ---------------------------------------------------------------------------
// o1ds_checker
// Port-level checks on the segmentation block, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module o1ds_checker
    import o1ds_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [SEG_START_W-1:0] o_segment_start,
    input logic [SEG_COUNT_W-1:0] o_segment_count,
    input logic                   o_last_result
);

    // Results are only delivered while loading is closed.
    `ASSERT_ALWAYS(a_no_load_while_emit, i_clk, o_out_valid |-> o_in_stall,
        "item taken while emitting")

    `ASSERT_CLK(a_count_nonzero, i_clk, i_rst_n, o_out_valid |-> (o_segment_count != '0),
        "zero segment count")

    // After the final item the block returns to loading.
    `ASSERT_CLK(a_last_ends_run, i_clk, i_rst_n,
        (o_out_valid && !i_out_stall && o_last_result) |=> (!o_out_valid && !o_in_stall),
        "run did not end after last item")

    // Within a run, the count is the same on every item.
    `ASSERT_CLK(a_count_steady, i_clk, i_rst_n,
        (o_out_valid && !i_out_stall && !o_last_result) |=>
            (o_out_valid && $stable(o_segment_count)),
        "count changed within a run")

    `ASSERT_CLK(a_hold_on_stall, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_segment_start)),
        "stalled item changed")

endmodule

bind optimal_1d_segmentation o1ds_checker u_o1ds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_segment_start(o_segment_start),
    .o_segment_count(o_segment_count),
    .o_last_result  (o_last_result)
);

FILE: test/tb_optimal_1d_segmentation.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_optimal_1d_segmentation
// Feeds sequences of signed samples to the segmentation block and checks
// every segment start it reports against a fixed-point dynamic program kept
// in a scoreboard, under several patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_optimal_1d_segmentation;
    import o1ds_pkg::*;

    localparam int CAPACITY    = DEF_MAX_SAMPLES;
    localparam int FRAC        = DEF_FRAC_BITS;
    localparam int CYCLE_CAP   = 2000000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [SEG_START_W-1:0] start;
        logic [SEG_COUNT_W-1:0] count;
        logic                   trunc;
        logic                   last;
    } t_seg_result;

    class segmentation_scoreboard;
        int                 held[$];
        bit                 overflow;
        t_seg_result        pending[$];
        int                 errors;
        longint unsigned    cost[CAPACITY][CAPACITY];
        longint unsigned    loss[CAPACITY+1][CAPACITY+1];
        int unsigned        split[CAPACITY+1][CAPACITY+1];

        function void segment_costs(int n);
            longint          s1, v;
            longint unsigned s2, m, a1, num;
            for (int i = 0; i < n; i++) begin
                s1 = 0;
                s2 = 0;
                for (int j = i; j < n; j++) begin
                    v = held[j];
                    m = j - i + 1;
                    s1 += v;
                    s2 += v * v;
                    a1 = (s1 < 0) ? -s1 : s1;
                    num = m * s2 - a1 * a1;
                    cost[i][j] = (j == i) ? 0 : ((num << FRAC) / m);
                end
            end
        endfunction

        function void min_losses(int n);
            longint unsigned best, cand, head;
            int unsigned     at;
            for (int r = 0; r <= CAPACITY; r++)
                for (int c = 0; c <= CAPACITY; c++) begin
                    loss[r][c] = 0;
                    split[r][c] = (r == c) ? r : 0;
                end
            for (int l = 3; l <= n; l++)
                for (int k = 2; k <= l; k++) begin
                    best = 0;
                    at = k;
                    for (int i = k; i <= l; i++) begin
                        head = (k == 2) ? cost[0][i-2] : loss[i-1][k-1];
                        cand = head + cost[i-1][l-1];
                        if (i == k || cand < best) begin
                            best = cand;
                            at = i;
                        end
                    end
                    loss[l][k] = best;
                    split[l][k] = at;
                end
        endfunction

        function longint unsigned gap(longint unsigned a, longint unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Accepted input item; a closing item produces the expected segments.
        function void note_sample(logic signed [SAMPLE_W-1:0] s, logic closing);
            int              n, count, row, idx;
            int              starts[CAPACITY];
            longint unsigned drop, d;
            t_seg_result     r;
            if (held.size() < CAPACITY) held.push_back(int'(s));
            else overflow = 1;
            if (!closing) return;
            n = held.size();
            segment_costs(n);
            min_losses(n);
            // Short sequences: each sample is its own segment.
            if (n <= SHORT_LIMIT) count = n;
            else begin
                count = 3;
                drop = gap(loss[n][2], loss[n][3]);
                for (int i = 3; i + 1 < n; i++) begin
                    d = gap(loss[n][i], loss[n][i+1]);
                    if (drop < d) begin
                        drop = d;
                        count = i + 1;
                    end
                end
            end
            foreach (starts[i]) starts[i] = 0;
            row = n;
            for (int c = count; c > 1; c--) begin
                idx = split[row][c] - 1;
                starts[c-1] = idx;
                row = idx;
            end
            for (int k = 0; k < count; k++) begin
                r.start = SEG_START_W'(starts[k]);
                r.count = SEG_COUNT_W'(count);
                r.trunc = overflow;
                r.last  = (k + 1 == count);
                pending.push_back(r);
            end
            held.delete();
            overflow = 0;
        endfunction

        function void check_segment(t_seg_result got);
            t_seg_result want;
            if (pending.size() == 0) begin
                $error("segment start %0d arrived with none expected", got.start);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.start !== want.start) begin
                $error("segment_start: expected %0d, got %0d", want.start, got.start);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("segment_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.trunc !== want.trunc) begin
                $error("truncated: expected %0d, got %0d", want.trunc, got.trunc);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_result: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        i_in_valid = 0;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_sample = '0;
    logic                        i_last_sample = 0;
    logic                        o_out_valid;
    logic                        i_out_stall = 0;
    logic [SEG_START_W-1:0]      o_segment_start;
    logic [SEG_COUNT_W-1:0]      o_segment_count;
    logic                        o_truncated;
    logic                        o_last_result;

    segmentation_scoreboard sb = new();
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 0;
    bit hold_used = 0;
    int hold_off = 0;
    int sent = 0;
    int cycles = 0;

    optimal_1d_segmentation i_dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("** optimal_1d_segmentation: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_seg_result got;
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_sample(i_sample, i_last_sample);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.start = o_segment_start;
            got.count = o_segment_count;
            got.trunc = o_truncated;
            got.last  = o_last_result;
            sb.check_segment(got);
        end
    end

    // Receiver: random stalls, plus one long hold-off once it is requested.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            i_out_stall <= 1;
            hold_off <= hold_off - 1;
        end else if (hold_req && !hold_used) begin
            i_out_stall <= 1;
            hold_off <= HOLD_CYCLES;
            hold_used <= 1;
        end else
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic closing);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1;
        i_sample      <= s;
        i_last_sample <= closing;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] clamp16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[SAMPLE_W-1:0];
    endfunction

    // One sequence: flat levels with noise, pure noise, or rail values.
    task automatic send_sequence(int len);
        int style, level, v;
        style = $urandom_range(2);
        level = $urandom_range(65535) - 32768;
        for (int i = 0; i < len; i++) begin
            if (style == 0) begin
                if ($urandom_range(99) < 25) level = $urandom_range(65535) - 32768;
                v = level + int'($urandom_range(200)) - 100;
            end else if (style == 1)
                v = $urandom_range(65535) - 32768;
            else
                v = $urandom_range(1) ? 32767 : -32768;
            send_sample(clamp16(v), i == len - 1);
        end
    endtask

    task automatic random_phase(int items);
        int start_count;
        start_count = sent;
        while (sent - start_count < items)
            send_sequence(($urandom_range(99) < 6) ? $urandom_range(36, 33)
                                                   : $urandom_range(12, 1));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: a single sample, a pair, a triple, ties, rails.
        send_sample(-16'sd32768, 1);
        send_sample(16'sd32767, 0);
        send_sample(-16'sd32768, 1);
        send_sample(16'sd0, 0);
        send_sample(16'sd0, 0);
        send_sample(16'sd0, 1);
        for (int i = 0; i < 4; i++) send_sample(16'sd5, i == 3);
        send_sample(-16'sd32768, 0);
        send_sample(-16'sd32768, 0);
        send_sample(16'sd32767, 0);
        send_sample(16'sd32767, 0);
        send_sample(16'sd0, 1);
        send_sample(16'sd1, 0);
        send_sample(16'sd2, 0);
        send_sample(16'sd100, 0);
        send_sample(16'sd101, 0);
        send_sample(-16'sd50, 0);
        send_sample(-16'sd51, 1);

        random_phase(60);
        send_gap_pct = 49;
        random_phase(60);
        send_gap_pct = 0;
        recv_stall_pct = 49;
        hold_req = 1;
        random_phase(60);
        send_gap_pct = 28;
        recv_stall_pct = 28;
        random_phase(60);
        // A full sequence whose closing sample is dropped.
        for (int i = 0; i < 33; i++) send_sample(clamp16(i * 900 - 15000), i == 32);
        i_in_valid <= 0;

        // Let the monitor note the closing item before waiting on results.
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** optimal_1d_segmentation: PASSED **");
        else
            $display("** optimal_1d_segmentation: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/o1ds_pkg.sv
src/o1ds_datapath.sv
src/o1ds_ctrl.sv
src/optimal_1d_segmentation.sv
src/o1ds_checker.sv
test/tb_optimal_1d_segmentation.sv
